>>> rtl/agpr_pkg.sv
`default_nettype none
package agpr_pkg;

  localparam int DEF_FRAMES    = 16;
  localparam int DEF_PAGE_BITS = 16;

  localparam int CFG_W      = 5;
  localparam int AGE_W      = 8;
  localparam int FIDX_OUT_W = 4;
  localparam int EVICT_W    = 16;
  localparam int FAULT_W    = 32;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_FRAMES_IN_USE = 2'd0;
  localparam logic [CFG_W-1:0]      FRAMES_IN_USE_RST = 5'd16;

  localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;
  // a freshly loaded frame starts at AGE_TOP and is aged once with its mark set
  localparam logic [AGE_W-1:0] AGE_FILL = AGE_TOP | (AGE_TOP >> 1);

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

endpackage
`default_nettype wire

>>> rtl/agpr_ram.sv
`default_nettype none
module agpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/aging_page_replacement_unit.sv
// Aging page replacement unit.
// Input channel (in_valid / in_stall / in_page): one page reference per
// transaction. Result channel (out_valid / out_stall / out_*): one result per
// reference, in order: hit flag, frame now holding the page, evicted page (if
// any) and the saturating fault count after this reference.
// Configuration: APB-style port, register frames_in_use at byte address 0
// (0 acts as 1, values above FRAMES act as FRAMES); write it only while idle.
// Frame pages and ages live in one RAM with a registered read; the
// scan reads every active frame once, writes back its aged counter in the
// following cycle, then patches the chosen frame in one more write.
// A reference reads its active frames one after another through the single
// RAM read port. One reference is in flight at a time, so the next one is
// accepted only once the previous result has left S_EMIT.
// While the result register is stalled the finished result is held there and
// the next reference is still taken; a second result waits for the first.
// Reset (rst_n low, synchronous) empties all frames, clears the fault count
// and restores frames_in_use to 16. No clearing pass is needed.
`default_nettype none
module aging_page_replacement_unit #(
  parameter int FRAMES    = agpr_pkg::DEF_FRAMES,
  parameter int PAGE_BITS = agpr_pkg::DEF_PAGE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PAGE_BITS-1:0]                in_page,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [agpr_pkg::FIDX_OUT_W-1:0]     out_frame_index,
  output logic                                out_evicted_valid,
  output logic [agpr_pkg::EVICT_W-1:0]        out_evicted_page,
  output logic [agpr_pkg::FAULT_W-1:0]        out_fault_count,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [agpr_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [agpr_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [agpr_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import agpr_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int RAM_W  = PAGE_BITS + AGE_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_EMIT} state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     frames_r;
  logic [CNT_W-1:0]     n_act;
  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 rvld_r;
  logic [FIDX_W-1:0]    ridx_r;
  logic                 hit_found_r;
  logic [FIDX_W-1:0]    hit_idx_r;
  logic [AGE_W-1:0]     hit_age_r;
  logic                 empty_found_r;
  logic [FIDX_W-1:0]    empty_idx_r;
  logic [FIDX_W-1:0]    min_idx_r;
  logic [AGE_W-1:0]     min_age_r;
  logic [PAGE_BITS-1:0] min_page_r;
  logic [FIDX_W-1:0]    slot_r;
  logic                 evict_r;
  logic [FRAMES-1:0]    valid_r;
  logic [FAULT_W-1:0]   faults_r;
  logic                 out_valid_r;

  logic                 cfg_wr;
  logic                 accept;
  logic                 scan_last;
  logic [FIDX_W-1:0]    slot;
  logic                 rd_en;
  logic [FIDX_W-1:0]    rd_addr;
  logic [RAM_W-1:0]     rd_data;
  logic [PAGE_BITS-1:0] rd_pg;
  logic [AGE_W-1:0]     rd_age;
  logic                 wr_en;
  logic [FIDX_W-1:0]    wr_addr;
  logic [RAM_W-1:0]     wr_data;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_FRAMES_IN_USE) ? APB_DATA_W'(frames_r) : '0;

  always_comb begin
    if (frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(frames_r) > FRAMES) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  assign rd_pg  = rd_data[RAM_W-1:AGE_W];
  assign rd_age = rd_data[AGE_W-1:0];

  assign scan_last = rvld_r && ((CNT_W'(ridx_r) + CNT_W'(1)) == n_act);

  always_comb begin
    if (hit_found_r) begin
      slot = hit_idx_r;
    end else if (empty_found_r) begin
      slot = empty_idx_r;
    end else begin
      slot = min_idx_r;
    end
  end

  // issue one read per active frame; write back the aged entry in the cycle after its read
  assign rd_en   = accept || ((state_r == S_SCAN) && (rd_cnt_r < n_act));
  assign rd_addr = (state_r == S_IDLE) ? '0 : rd_cnt_r[FIDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ridx_r;
    wr_data = {rd_pg, 1'b0, rd_age[AGE_W-1:1]};
    case (state_r)
      S_SCAN: begin
        wr_en = rvld_r;
      end
      S_FIX: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = {page_r, hit_found_r ? {1'b1, hit_age_r[AGE_W-1:1]} : AGE_FILL};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  agpr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frames_r    <= FRAMES_IN_USE_RST;
      rvld_r      <= 1'b0;
      valid_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr == REG_FRAMES_IN_USE)) begin
        frames_r <= cfg_pwdata[CFG_W-1:0];
      end

      rvld_r <= rd_en;
      ridx_r <= rd_addr;
      if (rd_en) begin
        rd_cnt_r <= (state_r == S_IDLE) ? CNT_W'(1) : rd_cnt_r + CNT_W'(1);
      end

      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            page_r        <= in_page;
            hit_found_r   <= 1'b0;
            empty_found_r <= 1'b0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rvld_r) begin
            if (!hit_found_r && valid_r[ridx_r] && (rd_pg == page_r)) begin
              hit_found_r <= 1'b1;
              hit_idx_r   <= ridx_r;
              hit_age_r   <= rd_age;
            end
            if (!empty_found_r && !valid_r[ridx_r]) begin
              empty_found_r <= 1'b1;
              empty_idx_r   <= ridx_r;
            end
            // strict compare keeps the lowest index on ties
            if ((ridx_r == '0) || (rd_age < min_age_r)) begin
              min_idx_r  <= ridx_r;
              min_age_r  <= rd_age;
              min_page_r <= rd_pg;
            end
          end
          if (scan_last) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          valid_r[slot] <= 1'b1;
          slot_r        <= slot;
          evict_r       <= !hit_found_r && !empty_found_r;
          if (!hit_found_r && (faults_r != FAULT_MAX)) begin
            faults_r <= faults_r + FAULT_W'(1);
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_hit           <= hit_found_r;
            out_frame_index   <= FIDX_OUT_W'(slot_r);
            out_evicted_valid <= evict_r;
            out_evicted_page  <= evict_r ? EVICT_W'(min_page_r) : '0;
            out_fault_count   <= faults_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("frame RAM read and write hit the same entry");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (faults_r >= $past(faults_r)))
    else $error("fault count decreased");

  a_valid_only_sets: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(valid_r) & ~valid_r) == '0))
    else $error("a resident frame became empty");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result loaded outside the emit step");

endmodule
`default_nettype wire

>>> dv/tb_aging_page_replacement_unit.sv
`timescale 1ns / 100ps

module tb_aging_page_replacement_unit;
  import agpr_pkg::*;

  localparam int NUM_FRAMES  = DEF_FRAMES;
  localparam int PAGE_W      = DEF_PAGE_BITS;
  localparam int POOL_SIZE   = 24;
  localparam int NUM_PHASES  = 8;
  // ~1150 references with worst stalls and gaps, several times over
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                  hit;
    logic [FIDX_OUT_W-1:0] frame_index;
    logic                  evicted_valid;
    logic [EVICT_W-1:0]    evicted_page;
    logic [FAULT_W-1:0]    fault_count;
  } page_outcome_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              hold_for_drain;
  } page_ref_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PAGE_W-1:0]     in_page = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [FIDX_OUT_W-1:0] out_frame_index;
  logic                  out_evicted_valid;
  logic [EVICT_W-1:0]    out_evicted_page;
  logic [FAULT_W-1:0]    out_fault_count;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow of the frame table
  logic [PAGE_W-1:0]  shadow_page  [NUM_FRAMES];
  logic               shadow_valid [NUM_FRAMES];
  logic [AGE_W-1:0]   shadow_age   [NUM_FRAMES];
  logic [FAULT_W-1:0] faults_total;
  logic [CFG_W-1:0]   frames_setting;

  page_ref_t     reference_q[$];
  page_outcome_t outcome_q[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  logic [PAGE_W-1:0] working_set [POOL_SIZE];

  int phase_frames [NUM_PHASES] = '{16, 4, 16, 31, 1, 8, 17, 15};
  int phase_idle   [NUM_PHASES] = '{0, 62, 0, 17, 0, 62, 0, 17};
  int phase_stall  [NUM_PHASES] = '{0, 0, 62, 17, 0, 0, 62, 17};
  int phase_count  [NUM_PHASES] = '{200, 150, 150, 150, 100, 150, 100, 150};

  aging_page_replacement_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned active_frames(input logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > NUM_FRAMES) return NUM_FRAMES;
    return int'(setting);
  endfunction

  // Look up the page, fill or replace on a miss, then age the active frames.
  function automatic page_outcome_t predict_reference(input logic [PAGE_W-1:0] page);
    page_outcome_t        res;
    int unsigned          n;
    int unsigned          slot;
    logic                 found;
    logic                 have_empty;
    logic [NUM_FRAMES-1:0] marks;
    res = '0;
    marks = '0;
    found = 1'b0;
    have_empty = 1'b0;
    slot = 0;
    n = active_frames(frames_setting);
    for (int i = 0; i < n; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      marks[slot] = 1'b1;
    end else begin
      if (faults_total != FAULT_MAX) faults_total = faults_total + 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!have_empty && !shadow_valid[i]) begin
          have_empty = 1'b1;
          slot = i;
        end
      end
      if (!have_empty) begin
        // lowest index wins a tie on age
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (shadow_age[i] < shadow_age[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = shadow_page[slot];
      end
      shadow_page[slot] = page;
      shadow_valid[slot] = 1'b1;
      shadow_age[slot] = AGE_TOP;
      marks[slot] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      shadow_age[i] = (shadow_age[i] >> 1) | (marks[i] ? AGE_TOP : '0);
    end
    res.hit = found;
    res.frame_index = slot[FIDX_OUT_W-1:0];
    res.fault_count = faults_total;
    return res;
  endfunction

  // Driver: present queued references, predict each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(predict_reference(in_page));
        reference_q.delete(0);
      end
      if (!in_valid || !in_stall) begin
        if (reference_q.size() != 0 &&
            !(reference_q[0].hold_for_drain && outcome_q.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_page <= reference_q[0].page;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] expv,
                              input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    page_outcome_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual frame %0d page %0h",
                   $time, out_frame_index, out_evicted_page);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          report_field("hit", 32'(want.hit), 32'(out_hit));
          report_field("frame_index", 32'(want.frame_index), 32'(out_frame_index));
          report_field("evicted_valid", 32'(want.evicted_valid), 32'(out_evicted_valid));
          report_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
          report_field("fault_count", want.fault_count, out_fault_count);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (reference_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
  endtask

  // Write the register, then read it back.
  task automatic set_frames_in_use(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_FRAMES_IN_USE;
    cfg_pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    frames_setting = value;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    report_field("frames_in_use readback", APB_DATA_W'(value), cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic queue_reference(input logic [PAGE_W-1:0] page, input logic hold);
    page_ref_t item;
    item.page = page;
    item.hold_for_drain = hold;
    reference_q.push_back(item);
  endtask

  initial begin
    int unsigned       act;
    int unsigned       pick;
    logic [PAGE_W-1:0] pg;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      shadow_page[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i] = '0;
    end
    faults_total = '0;
    frames_setting = FRAMES_IN_USE_RST;
    for (int i = 0; i < POOL_SIZE; i++) working_set[i] = PAGE_W'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: extremes, a hit, alternating bit patterns
    queue_reference(16'h0000, 1'b0);
    queue_reference(16'hFFFF, 1'b0);
    queue_reference(16'h0000, 1'b0);
    queue_reference(16'hAAAA, 1'b0);
    queue_reference(16'h5555, 1'b0);
    wait_drained();

    // zero acts as one frame: hit, replace, and a page resident only outside
    set_frames_in_use(5'd0);
    queue_reference(16'h0000, 1'b0);
    queue_reference(16'h1234, 1'b0);
    queue_reference(16'h1234, 1'b0);
    queue_reference(16'hFFFF, 1'b0);
    wait_drained();

    // three frames with stale ages; duplicate page resident in two frames
    set_frames_in_use(5'd3);
    queue_reference(16'hFFFF, 1'b0);
    queue_reference(16'h0F0F, 1'b0);
    queue_reference(16'hF0F0, 1'b1);
    queue_reference(16'h8001, 1'b0);
    queue_reference(16'h0F0F, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_frames_in_use(phase_frames[p][CFG_W-1:0]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      act = active_frames(frames_setting);
      // refresh part of the working set, keep the rest to revisit stale frames
      for (int i = 0; i < 4; i++) working_set[$urandom_range(POOL_SIZE - 1)] = PAGE_W'($urandom);
      for (int k = 0; k < phase_count[p]; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) pg = PAGE_W'($urandom);
        else if (pick < 14) pg = pick[0] ? '1 : '0;
        else if (pick < 55) pg = working_set[$urandom_range(act / 2)];
        else pg = working_set[$urandom_range(act + 3)];
        // hold off once per phase until every result is back
        queue_reference(pg, k == 40);
      end
      wait_drained();
    end

    repeat (4 * NUM_FRAMES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
